// ----- hw/rtl/hpq_pkg.sv -----
// Shared types and constants for the binary max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package hpq_pkg;

   localparam int KEY_W = 32;
   localparam int CNT_W = 8;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_RD,
      S_DN_CMP
   } state_type;

   // completion of one item, handed to the response register
   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic signed [KEY_W-1:0] removed;
   } done_type;

   function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
      return a < b;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/hpq_mem.sv -----
// Key store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module hpq_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic                            clock,
   input  wire logic                            we,
   input  wire logic [AW-1:0]                   waddr,
   input  wire logic signed [hpq_pkg::KEY_W-1:0] wdata,
   input  wire logic [AW-1:0]                   raddr0,
   input  wire logic [AW-1:0]                   raddr1,
   output logic signed [hpq_pkg::KEY_W-1:0]     rdata0,
   output logic signed [hpq_pkg::KEY_W-1:0]     rdata1
);
   import hpq_pkg::*;

   logic signed [KEY_W-1:0] key_store_ff [DEPTH];
   logic signed [KEY_W-1:0] rd0_ff;
   logic signed [KEY_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         key_store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd0_ff <= key_store_ff[raddr0];
      rd1_ff <= key_store_ff[raddr1];
   end

   assign rdata0 = rd0_ff;
   assign rdata1 = rd1_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/hpq_ctrl.sv -----
// Sequencer for insert (sift up) and remove-max (sift down) over the key store.
`timescale 1ns / 1ps
`default_nettype none
module hpq_ctrl #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            operation,
   input  wire logic signed [hpq_pkg::KEY_W-1:0] key,
   output logic                                 busy,
   output logic                                 mem_we,
   output logic [AW-1:0]                        mem_waddr,
   output logic signed [hpq_pkg::KEY_W-1:0]     mem_wdata,
   output logic [AW-1:0]                        mem_raddr0,
   output logic [AW-1:0]                        mem_raddr1,
   input  wire logic signed [hpq_pkg::KEY_W-1:0] mem_rdata0,
   input  wire logic signed [hpq_pkg::KEY_W-1:0] mem_rdata1,
   output hpq_pkg::done_type                    done,
   output logic [AW-1:0]                        count,
   output logic signed [hpq_pkg::KEY_W-1:0]     root
);
   import hpq_pkg::*;

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROOT_SLOT = AW'(1);

   state_type               state_ff, state_in;
   logic [AW-1:0]           count_ff, count_in;
   logic [AW-1:0]           idx_ff, idx_in;       // insert position / sift-down parent
   logic [AW:0]             child_ff, child_in;
   logic signed [KEY_W-1:0] key_ff, key_in;       // inserted or moving key
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   logic signed [KEY_W-1:0] root_ff;

   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   logic [AW-1:0]           child_lo;
   logic                    child_in_range;
   logic                    right_exists;
   logic                    sel_right;
   logic signed [KEY_W-1:0] child_val;
   logic [AW-1:0]           pick;
   logic                    up_move;
   logic                    dn_move;

   assign accept         = start && (state_ff == S_IDLE);
   assign is_full        = (count_ff == LAST_SLOT);
   assign is_empty       = (count_ff == '0);
   assign child_lo       = child_ff[AW-1:0];
   assign child_in_range = (child_ff <= {1'b0, count_ff});
   assign right_exists   = (child_ff < {1'b0, count_ff});
   assign sel_right      = right_exists && key_less(mem_rdata0, mem_rdata1);
   assign child_val      = sel_right ? mem_rdata1 : mem_rdata0;
   assign pick           = sel_right ? child_lo + AW'(1) : child_lo;
   assign up_move        = key_less(mem_rdata0, key_ff);
   assign dn_move        = key_less(key_ff, child_val);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (operation == OP_INSERT) begin
                  if (!is_full) state_in = S_UP_RD;
               end else begin
                  if (!is_empty) state_in = S_DN_LAST;
               end
            end
         end
         S_UP_RD: begin
            state_in = (idx_ff == ROOT_SLOT) ? S_IDLE : S_UP_CMP;
         end
         S_UP_CMP: begin
            state_in = up_move ? S_UP_RD : S_IDLE;
         end
         S_DN_LAST: begin
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            state_in = child_in_range ? S_DN_CMP : S_IDLE;
         end
         S_DN_CMP: begin
            state_in = dn_move ? S_DN_RD : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory accesses, datapath updates and completion
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = key_ff;
      mem_raddr0   = idx_ff >> 1;
      mem_raddr1   = child_lo + AW'(1);
      done.valid   = 1'b0;
      done.status  = ST_OK;
      done.removed = removed_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      child_in     = child_ff;
      key_in       = key_ff;
      removed_in   = removed_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (operation == OP_INSERT) begin
                  if (is_full) begin
                     done.valid   = 1'b1;
                     done.status  = ST_FULL;
                     done.removed = '0;
                  end else begin
                     count_in   = count_ff + AW'(1);
                     idx_in     = count_ff + AW'(1);
                     key_in     = key;
                     removed_in = '0;
                  end
               end else begin
                  if (is_empty) begin
                     done.valid   = 1'b1;
                     done.status  = ST_EMPTY;
                     done.removed = '0;
                  end else begin
                     removed_in = root_ff;
                     count_in   = count_ff - AW'(1);
                     mem_raddr0 = count_ff;   // last entry moves to the root
                  end
               end
            end
         end
         S_UP_RD: begin
            if (idx_ff == ROOT_SLOT) begin
               mem_we     = 1'b1;
               done.valid = 1'b1;
            end
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            if (up_move) begin
               mem_wdata = mem_rdata0;
               idx_in    = idx_ff >> 1;
            end else begin
               done.valid = 1'b1;
            end
         end
         S_DN_LAST: begin
            key_in   = mem_rdata0;
            idx_in   = ROOT_SLOT;
            child_in = (AW+1)'(2);
         end
         S_DN_RD: begin
            if (child_in_range) begin
               mem_raddr0 = child_lo;
            end else begin
               mem_we     = !is_empty;
               done.valid = 1'b1;
            end
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (dn_move) begin
               mem_wdata = child_val;
               idx_in    = pick;
               child_in  = {pick, 1'b0};
            end else begin
               done.valid = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      child_ff   <= child_in;
      key_ff     <= key_in;
      removed_ff <= removed_in;
      // shadow of slot 1 so the maximum is always at hand
      if (mem_we && (mem_waddr == ROOT_SLOT)) begin
         root_ff <= mem_wdata;
      end
   end

   assign busy  = (state_ff != S_IDLE);
   assign count = count_ff;
   assign root  = root_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/max_heap_priority_queue_top.sv -----
// Binary max-heap priority queue: store, sequencer and response register.
// Insert sifts the new key up from the new last slot; remove moves the last entry to the root
// and sifts it down; the moving key passes at most log2(STORE_DEPTH) - 1 levels.
// A word rejected as full or empty is answered straight from idle.
// One word at a time; busy drops in the strobe cycle and the strobe is never held off.
// Reset clears the count and the sequencer; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module max_heap_priority_queue_top #(
   parameter int STORE_DEPTH = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_operation,
   input  wire logic signed [hpq_pkg::KEY_W-1:0] req_key,
   output logic                                 rsp_valid,
   output logic signed [hpq_pkg::KEY_W-1:0]     rsp_removed_key,
   output logic signed [hpq_pkg::KEY_W-1:0]     rsp_top_key,
   output logic [hpq_pkg::CNT_W-1:0]            rsp_entry_count,
   output logic [1:0]                           rsp_status
);
   import hpq_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic signed [KEY_W-1:0] mem_wdata;
   logic [AW-1:0]           mem_raddr0;
   logic [AW-1:0]           mem_raddr1;
   logic signed [KEY_W-1:0] mem_rdata0;
   logic signed [KEY_W-1:0] mem_rdata1;
   done_type                done;
   logic [AW-1:0]           count;
   logic signed [KEY_W-1:0] root;
   logic [AW+CNT_W-1:0]     count_wide;

   logic                    rsp_valid_ff;
   logic signed [KEY_W-1:0] rsp_removed_ff;
   status_type              rsp_status_ff;

   hpq_mem #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock  (clock),
      .we     (mem_we),
      .waddr  (mem_waddr),
      .wdata  (mem_wdata),
      .raddr0 (mem_raddr0),
      .raddr1 (mem_raddr1),
      .rdata0 (mem_rdata0),
      .rdata1 (mem_rdata1)
   );

   hpq_ctrl #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .operation  (req_operation),
      .key        (req_key),
      .busy       (busy),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr0 (mem_raddr0),
      .mem_raddr1 (mem_raddr1),
      .mem_rdata0 (mem_rdata0),
      .mem_rdata1 (mem_rdata1),
      .done       (done),
      .count      (count),
      .root       (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_removed_ff <= done.removed;
         rsp_status_ff  <= done.status;
      end
   end

   // count and root are final by the edge at which the strobe rises and hold
   // until the next word is accepted
   assign count_wide      = {{CNT_W{1'b0}}, count};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_key = rsp_removed_ff;
   assign rsp_top_key     = (count != '0) ? root : '0;
   assign rsp_entry_count = count_wide[CNT_W-1:0];
   assign rsp_status      = rsp_status_ff;

endmodule
`default_nettype wire

// ----- tb/max_heap_priority_queue_top_tb.sv -----
// Self-checking testbench for the max-heap priority queue: directed, fill-to-full and random.
`timescale 1ns / 1ps
module max_heap_priority_queue_top_tb;
   import hpq_pkg::*;

   localparam int HEAP_SLOTS  = 256;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_GAP     = 400;

   typedef struct {
      logic signed [KEY_W-1:0] removed;
      logic signed [KEY_W-1:0] top;
      logic [CNT_W-1:0]        count;
      status_type              status;
   } heap_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    req_operation = OP_INSERT;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic signed [KEY_W-1:0] rsp_removed_key;
   logic signed [KEY_W-1:0] rsp_top_key;
   logic [CNT_W-1:0]        rsp_entry_count;
   logic [1:0]              rsp_status;

   // shadow heap, 1-based like the block
   logic signed [KEY_W-1:0] heap_keys [0:HEAP_SLOTS-1];
   int                      shadow_count = 0;
   heap_result_type         expected_results [$];

   int idle_pct      = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int error_count   = 0;
   int full_rejects  = 0;
   int empty_rejects = 0;
   int peak_size     = 0;
   int stall_cycles  = 0;

   max_heap_priority_queue_top #(
      .STORE_DEPTH(HEAP_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_removed_key(rsp_removed_key),
      .rsp_top_key    (rsp_top_key),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status     (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // applies one word to the shadow heap and returns what the block should answer
   function automatic heap_result_type heap_apply(input logic op,
                                                  input logic signed [KEY_W-1:0] key);
      heap_result_type         r;
      int                      slot;
      int                      child;
      logic signed [KEY_W-1:0] moving;
      r.removed = '0;
      r.status  = ST_OK;
      if (op == OP_INSERT) begin
         if (shadow_count >= HEAP_SLOTS - 1) begin
            r.status = ST_FULL;
            full_rejects++;
         end else begin
            shadow_count++;
            slot = shadow_count;
            while (slot != 1 && heap_keys[slot / 2] < key) begin
               heap_keys[slot] = heap_keys[slot / 2];
               slot = slot / 2;
            end
            heap_keys[slot] = key;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = ST_EMPTY;
            empty_rejects++;
         end else begin
            r.removed = heap_keys[1];
            moving    = heap_keys[shadow_count];
            shadow_count--;
            slot  = 1;
            child = 2;
            while (child <= shadow_count) begin
               // left child wins a tie
               if (child < shadow_count && heap_keys[child] < heap_keys[child + 1])
                  child++;
               if (!(moving < heap_keys[child]))
                  break;
               heap_keys[slot] = heap_keys[child];
               slot  = child;
               child = child * 2;
            end
            if (shadow_count != 0)
               heap_keys[slot] = moving;
         end
      end
      if (shadow_count > peak_size)
         peak_size = shadow_count;
      r.top   = (shadow_count != 0) ? heap_keys[1] : '0;
      r.count = CNT_W'(shadow_count);
      return r;
   endfunction

   // mostly full-range keys, with clusters of small values for ties and the extremes
   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(9))
         6, 7: k = $signed($urandom_range(16)) - 8;
         8: begin
            case ($urandom_range(3))
               0: k = 32'sh7FFF_FFFF;
               1: k = 32'sh8000_0000;
               2: k = '0;
               default: k = -1;
            endcase
         end
         9: k = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                  : 32'sh8000_0000 + $urandom_range(3);
         default: k = $urandom;
      endcase
      return k;
   endfunction

   task automatic send_word(input logic op, input logic signed [KEY_W-1:0] key);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      do @(posedge clock); while (busy !== 1'b0);
      expected_results.push_back(heap_apply(op, key));
      words_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_remove();
      send_word(OP_REMOVE, '0);
      send_word(OP_REMOVE, 32'shFFFF_FFFF);
   endtask

   task automatic test_key_extremes();
      send_word(OP_INSERT, 32'sh8000_0000);
      send_word(OP_INSERT, '0);
      send_word(OP_INSERT, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, -1);
      send_word(OP_INSERT, 1);
      repeat (5) send_word(OP_REMOVE, pick_key());
      send_word(OP_REMOVE, 32'sh7FFF_FFFF);
   endtask

   task automatic test_equal_keys();
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 7);
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 7);
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 7);
      repeat (4) send_word(OP_REMOVE, '0);
   endtask

   task automatic test_fill_to_full();
      while (shadow_count < HEAP_SLOTS - 1)
         send_word(OP_INSERT, pick_key());
      repeat (3) send_word(OP_INSERT, pick_key());
      while (shadow_count > 0)
         send_word(OP_REMOVE, pick_key());
      repeat (2) send_word(OP_REMOVE, pick_key());
   endtask

   // insert bias drifts so the count wanders over the whole range
   task automatic test_random_mix(input int n_words);
      int insert_pct;
      insert_pct = 50;
      for (int i = 0; i < n_words; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(5))
               0: insert_pct = 95;
               1: insert_pct = 5;
               default: insert_pct = $urandom_range(30, 70);
            endcase
         end
         send_word(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE, pick_key());
      end
   endtask

   always @(posedge clock) begin : check_results
      heap_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_removed_key !== want.removed)
               report_mismatch($sformatf("word %0d removed_key got %0d want %0d",
                                         words_checked, rsp_removed_key, want.removed));
            if (rsp_top_key !== want.top)
               report_mismatch($sformatf("word %0d top_key got %0d want %0d",
                                         words_checked, rsp_top_key, want.top));
            if (rsp_entry_count !== want.count)
               report_mismatch($sformatf("word %0d entry_count got %0d want %0d",
                                         words_checked, rsp_entry_count, want.count));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("word %0d status got %0d want %0d",
                                         words_checked, rsp_status, want.status));
            words_checked++;
         end
      end
   end

   // counts cycles in which no word moves on either side
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      test_empty_remove();
      test_key_extremes();
      test_equal_keys();
      test_fill_to_full();
      wait_drained();

      idle_pct = 83;
      test_random_mix(440);
      wait_drained();

      idle_pct = 24;
      test_random_mix(440);
      wait_drained();

      idle_pct = 0;
      test_random_mix(440);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results still outstanding at end of run");

      $display("Sent %0d words, checked %0d results; heap peaked at %0d keys",
               words_sent, words_checked, peak_size);
      $display("Rejected inserts when full: %0d, rejected removes when empty: %0d",
               full_rejects, empty_rejects);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
